>>> rtl/piaw_pkg.sv
// ----------------------------------------------------------------------------
// piaw_pkg: shared types and helpers for the annular wedge point test
// Coordinate reduction, geometry bundle passed from the register file.
// ----------------------------------------------------------------------------
package piaw_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW_EFF      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int CSHIFT      = 32 - CW_EFF;

    // register indexes of the configuration channel
    localparam logic [2:0] REG_V_FIRST  = 3'd0;
    localparam logic [2:0] REG_V_SECOND = 3'd1;
    localparam logic [2:0] REG_V_NLAST  = 3'd2;
    localparam logic [2:0] REG_V_LAST   = 3'd3;
    localparam logic [2:0] REG_OUTER    = 3'd4;
    localparam logic [2:0] REG_INNER    = 3'd5;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [32:0] t_delta;

    typedef struct packed {
        t_coord      x0;
        t_coord      y0;
        t_delta      dx1;      // x1 - x0
        t_delta      dy1;      // y1 - y0
        t_coord      xa;
        t_coord      ya;
        t_delta      dxb;      // xb - xa
        t_delta      dyb;      // yb - ya
        logic        y_same;   // y1 and ya nonzero with equal sign
        logic        y_diff;   // y1 and ya nonzero with opposite sign
        logic        xsum_neg; // x1 + xa < 0
        logic [61:0] ro_sq;
        logic [61:0] ri_sq;
    } t_geom;

    // Keep the low CW_EFF bits and sign-extend from there
    function automatic t_coord reduce(input logic [31:0] v);
        t_coord t;
        t = signed'(v << CSHIFT);
        return t >>> CSHIFT;
    endfunction

    function automatic t_delta diff33(input t_coord a, input t_coord b);
        return {a[31], a} - {b[31], b};
    endfunction

endpackage

>>> rtl/piaw_cfg.sv
// ----------------------------------------------------------------------------
// piaw_cfg: configuration register file
// Holds the four vertices and radius squares, derives edge geometry.
// ----------------------------------------------------------------------------
module piaw_cfg import piaw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [2:0]  i_index,
    input  logic [63:0] i_data,
    output t_geom       o_geom
);

    logic [63:0] r_v0, r_v1, r_va, r_vb;
    logic [61:0] r_ro_sq, r_ri_sq;
    logic [30:0] w_rad;
    t_coord      w_x1, w_y1, w_xb, w_yb, w_xa;
    t_delta      w_xsum;

    assign w_rad = i_data[30:0];

    // Store vertices; square the radii as they are written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= '0;
            r_v1    <= '0;
            r_va    <= '0;
            r_vb    <= '0;
            r_ro_sq <= 62'h1_0000_0000;
            r_ri_sq <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                REG_V_FIRST:  r_v0 <= i_data;
                REG_V_SECOND: r_v1 <= i_data;
                REG_V_NLAST:  r_va <= i_data;
                REG_V_LAST:   r_vb <= i_data;
                REG_OUTER:    r_ro_sq <= 62'(w_rad) * 62'(w_rad);
                REG_INNER:    r_ri_sq <= 62'(w_rad) * 62'(w_rad);
                default:      ;
            endcase
        end
    end

    // Derive edge deltas and vertex sign tests
    assign w_x1 = reduce(r_v1[63:32]);
    assign w_y1 = reduce(r_v1[31:0]);
    assign w_xb = reduce(r_vb[63:32]);
    assign w_yb = reduce(r_vb[31:0]);
    assign w_xa = reduce(r_va[63:32]);

    assign w_xsum = {w_x1[31], w_x1} + {w_xa[31], w_xa};

    always_comb begin
        o_geom.x0  = reduce(r_v0[63:32]);
        o_geom.y0  = reduce(r_v0[31:0]);
        o_geom.xa  = w_xa;
        o_geom.ya  = reduce(r_va[31:0]);
        o_geom.dx1 = diff33(w_x1, o_geom.x0);
        o_geom.dy1 = diff33(w_y1, o_geom.y0);
        o_geom.dxb = diff33(w_xb, o_geom.xa);
        o_geom.dyb = diff33(w_yb, o_geom.ya);
        o_geom.y_same = (w_y1 != 0) && (o_geom.ya != 0) && (w_y1[31] == o_geom.ya[31]);
        o_geom.y_diff = (w_y1 != 0) && (o_geom.ya != 0) && (w_y1[31] != o_geom.ya[31]);
        o_geom.xsum_neg = w_xsum[32];
        o_geom.ro_sq = r_ro_sq;
        o_geom.ri_sq = r_ri_sq;
    end

endmodule

>>> rtl/piaw_side.sv
// ----------------------------------------------------------------------------
// piaw_side: three-stage side sign of one wedge edge
// Sign of dx*(y-ya) - (x-xa)*dy, flipped for a negative divisor.
// ----------------------------------------------------------------------------
module piaw_side import piaw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_x,
    input  t_coord i_y,
    input  t_coord i_xa,
    input  t_coord i_ya,
    input  t_delta i_dx,
    input  t_delta i_dy,
    output logic   o_neg,
    output logic   o_pos
);

    t_delta             r_ex, r_ey;
    logic signed [65:0] r_num, r_prd;
    logic signed [66:0] r_diff;
    logic               w_dneg, w_dpos;

    // Offsets, products, then the difference
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex   <= diff33(i_x, i_xa);
            r_ey   <= diff33(i_y, i_ya);
            r_num  <= 66'(i_dx) * 66'(r_ey);
            r_prd  <= 66'(r_ex) * 66'(i_dy);
            r_diff <= 67'(r_num) - 67'(r_prd);
        end
    end

    // Zero divisor leaves the product at zero; zero over zero gives neither sign
    assign w_dneg = r_diff[66];
    assign w_dpos = !r_diff[66] && (r_diff != '0);
    assign o_neg  = i_dy[32] ? w_dpos : w_dneg;
    assign o_pos  = i_dy[32] ? w_dneg : w_dpos;

endmodule

>>> rtl/piaw_radius.sv
// ----------------------------------------------------------------------------
// piaw_radius: three-stage squared distance x*x + y*y
// Register the point, square each coordinate, then add.
// ----------------------------------------------------------------------------
module piaw_radius import piaw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_coord      i_x,
    input  t_coord      i_y,
    output logic [63:0] o_dist
);

    t_coord             r_x, r_y;
    logic signed [63:0] r_sx, r_sy;
    logic [63:0]        r_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_y  <= i_y;
            r_sx <= 64'(r_x) * 64'(r_x);
            r_sy <= 64'(r_y) * 64'(r_y);
            r_d  <= r_sx + r_sy;
        end
    end

    assign o_dist = r_d;

endmodule

>>> rtl/point_in_annular_wedge_core.sv
// ----------------------------------------------------------------------------
// point_in_annular_wedge_core: point in annular wedge test
// Classifies each streamed point against two wedge edges and a ring.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries one point per transfer: x_coord in
//   tdata[31:0], y_coord in tdata[63:32], signed Q16.16.
//   Master stream (o_m_*) returns one result per point in tdata[0].
//   Configuration channel (i_cfg_*) writes vertex and radius registers by
//   index; it is always ready. Write it only while no point is in flight.
//   One point is taken per cycle unless the master side stalls. The depth
//   is set by the 33x33 edge multipliers: offset, product, difference, then
//   the classification into the output register.
//   A stall on the master side freezes the whole pipeline; the slave side
//   stays ready while the output register is empty or being drained.
//   Reset empties the pipeline, clears the vertices, sets the outer radius
//   to 1.0 and the inner radius to 0.
// ----------------------------------------------------------------------------
module point_in_annular_wedge_core import piaw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] x_coord, [63:32] y_coord
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] inside_res, [7:1] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_geom       w_geom;
    logic        w_adv;
    logic [2:0]  r_v;
    logic        r_inside;
    t_coord      w_x, w_y;
    logic        w_n1, w_p1, w_n2, w_p2;
    logic [63:0] w_dist;
    logic        n_inside, w_excl;

    assign o_cfg_ready = 1'b1;

    piaw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_geom  (w_geom)
    );

    // Advance the whole pipeline whenever the output register can move
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    assign w_x = reduce(i_s_tdata[31:0]);
    assign w_y = reduce(i_s_tdata[63:32]);

    piaw_side u_side1 (
        .i_clk (i_clk), .i_en (w_adv), .i_x (w_x), .i_y (w_y),
        .i_xa  (w_geom.x0), .i_ya (w_geom.y0),
        .i_dx  (w_geom.dx1), .i_dy (w_geom.dy1),
        .o_neg (w_n1), .o_pos (w_p1)
    );

    piaw_side u_side2 (
        .i_clk (i_clk), .i_en (w_adv), .i_x (w_x), .i_y (w_y),
        .i_xa  (w_geom.xa), .i_ya (w_geom.ya),
        .i_dx  (w_geom.dxb), .i_dy (w_geom.dyb),
        .o_neg (w_n2), .o_pos (w_p2)
    );

    piaw_radius u_radius (
        .i_clk (i_clk), .i_en (w_adv), .i_x (w_x), .i_y (w_y),
        .o_dist (w_dist)
    );

    // Classify: edge exclusions, then the ring bounds
    always_comb begin
        w_excl = (w_n1 && w_n2)
              || (w_p1 && w_p2 && w_geom.y_same)
              || (w_geom.y_diff && ((w_n1 && w_p2) || (w_p1 && w_n2)) && w_geom.xsum_neg);
        n_inside = !w_excl && (w_dist <= {2'b00, w_geom.ro_sq})
                           && (w_dist >= {2'b00, w_geom.ri_sq});
    end

    // Carry valid bits alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            o_m_tvalid <= 1'b0;
        end else if (w_adv) begin
            r_v        <= {r_v[1:0], i_s_tvalid};
            o_m_tvalid <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_inside <= n_inside;
        end
    end

    assign o_m_tdata = {7'd0, r_inside};

endmodule

>>> rtl/piaw_chk.sv
// ----------------------------------------------------------------------------
// piaw_chk: port-level checks for the annular wedge core
// Reset, stall and latency behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module piaw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // Input ready whenever the output register is free to move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input not ready with free output");

    // A transfer reaches the output if the pipeline keeps advancing
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) ##1 o_s_tready ##1 o_s_tready ##1 o_s_tready
            |=> o_m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind point_in_annular_wedge_core piaw_chk u_piaw_chk (.*);
